FILE: sv/hashed_name_cache_unit_macros.svh
// Assertion macros for the hashed name cache unit.
`ifndef HASHED_NAME_CACHE_UNIT_MACROS_SVH
`define HASHED_NAME_CACHE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define HNC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define HNC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HNC_ASSERT(label, prop, msg)
`define HNC_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: sv/hnc_pkg.sv
// Shared types and constants of the hashed name cache unit.
`default_nettype none
package hnc_pkg;

  localparam int TableBits = 10;
  localparam int NameMax   = 63;
  localparam int NameBytes = 63;
  localparam int KeyW      = 8 * NameBytes;
  localparam int TblSize   = 1 << TableBits;
  localparam int CountW    = TableBits + 1;
  localparam int SlotW     = 10;
  localparam int UsedLo    = (TableBits > 5) ? 5 : TableBits - 1;
  localparam int UsedW     = 1 << UsedLo;
  localparam int UsedRows  = TblSize >> UsedLo;
  localparam int RowBits   = TableBits - UsedLo;
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_RESERVED = 3'd1,
    ST_BYPASS   = 3'd2,
    ST_INVALID  = 3'd3,
    ST_DONE     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CMD_LOOKUP  = 3'd0,
    CMD_FILL    = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_INVALID = 3'd3,
    CMD_BYPASS  = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word2;
    logic [63:0] name_word3;
    logic [63:0] name_word4;
    logic [63:0] name_word5;
    logic [63:0] name_word6;
    logic [63:0] name_word7;
    logic [6:0]  name_length;
    logic [9:0]  fill_slot;
    logic [63:0] fill_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value;
    logic [9:0]  slot;
  } rsp_t;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [KeyW-1:0]        key;
    logic [TableBits-1:0]   home;
    logic [TableBits-1:0]   fill_slot;
    logic [63:0]            value;
  } cmd_t;

  typedef struct packed {
    logic              init_busy;
    logic [CountW-1:0] used_count;
  } bstat_t;

endpackage
`default_nettype wire

FILE: sv/hnc_front.sv
// Front end: accept transactions, classify names and hash them byte by byte.
`default_nettype none
module hnc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire hnc_pkg::req_t req_i,
  input  wire logic          hold_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output hnc_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_SEND = 3'b100
  } fstate_e;

  fstate_e               state_q, state_d;
  hnc_pkg::cmd_t         cmd_q, cmd_d;
  logic [31:0]           hash_q, hash_d;
  logic [5:0]            idx_q, idx_d;
  logic [5:0]            last_q, last_d;

  logic                  accept;
  logic [hnc_pkg::KeyW-1:0] name_all;
  logic [hnc_pkg::KeyW-1:0] key_c;
  logic [6:0]            scan;
  logic [6:0]            len_c;
  hnc_pkg::cmd_kind_e    kind_c;
  logic [7:0]            cur_byte;
  logic [31:0]           mix;

  assign full        = (state_q != F_IDLE) || hold_i;
  assign accept      = push && !full;
  assign cmd_valid_o = (state_q == F_SEND);
  assign cmd_o       = cmd_q;

  // Gather the name bytes; the top byte of the last word is never used
  assign name_all = {req_i.name_word7[55:0], req_i.name_word6, req_i.name_word5,
                     req_i.name_word4, req_i.name_word3, req_i.name_word2,
                     req_i.name_word1, req_i.name_word0};

  // Find the name end: first zero byte inside the requested length
  always_comb begin
    scan  = (req_i.name_length < 7'(hnc_pkg::NameBytes)) ? req_i.name_length
                                                         : 7'(hnc_pkg::NameBytes);
    len_c = req_i.name_length;
    for (int i = hnc_pkg::NameBytes - 1; i >= 0; i--) begin
      if ((7'(i) < scan) && (name_all[8*i +: 8] == 8'h00)) begin
        len_c = 7'(i);
      end
    end
    for (int i = 0; i < hnc_pkg::NameBytes; i++) begin
      key_c[8*i +: 8] = (7'(i) < len_c) ? name_all[8*i +: 8] : 8'h00;
    end
  end

  // Sort the transaction into a command kind
  always_comb begin
    case (req_i.action)
      hnc_pkg::ACT_FILL:  kind_c = hnc_pkg::CMD_FILL;
      hnc_pkg::ACT_CLEAR: kind_c = hnc_pkg::CMD_CLEAR;
      hnc_pkg::ACT_LOOKUP: begin
        if (len_c == 7'd0) begin
          kind_c = hnc_pkg::CMD_INVALID;
        end else if (len_c > 7'(hnc_pkg::NameMax)) begin
          kind_c = hnc_pkg::CMD_BYPASS;
        end else begin
          kind_c = hnc_pkg::CMD_LOOKUP;
        end
      end
      default: kind_c = hnc_pkg::CMD_INVALID;
    endcase
  end

  // One FNV-1a round per cycle
  assign cur_byte = cmd_q.key[8*idx_q +: 8];
  assign mix      = hash_q ^ {24'd0, cur_byte};

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    hash_d  = hash_q;
    idx_d   = idx_q;
    last_d  = last_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          cmd_d.kind      = kind_c;
          cmd_d.key       = key_c;
          cmd_d.home      = '0;
          cmd_d.fill_slot = hnc_pkg::TableBits'(req_i.fill_slot);
          cmd_d.value     = req_i.fill_value;
          hash_d          = hnc_pkg::FnvBasis;
          idx_d           = 6'd0;
          last_d          = 6'(len_c - 7'd1);
          state_d         = (kind_c == hnc_pkg::CMD_LOOKUP) ? F_HASH : F_SEND;
        end
      end
      F_HASH: begin
        hash_d = mix * hnc_pkg::FnvPrime;
        if (idx_q == last_q) begin
          cmd_d.home = hash_d[hnc_pkg::TableBits-1:0];
          state_d    = F_SEND;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      F_SEND: begin
        if (cmd_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    hash_q <= hash_d;
    idx_q  <= idx_d;
    last_q <= last_d;
  end

endmodule
`default_nettype wire

FILE: sv/hnc_queue.sv
// Short command queue between the front end and the table engine.
`default_nettype none
module hnc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire hnc_pkg::cmd_t wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output hnc_pkg::cmd_t      rd_data_o
);

  hnc_pkg::cmd_t               buf_q [hnc_pkg::QDepth];
  logic [hnc_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hnc_pkg::QPtrW:0]     cnt_q;
  logic                        do_wr, do_rd;

  assign wr_ready_o = (cnt_q != (hnc_pkg::QPtrW + 1)'(hnc_pkg::QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_ready_i && rd_valid_o;
  assign rd_data_o  = buf_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      buf_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: sv/hnc_back.sv
// Table engine: probe, reserve, fill and clear the slot memories.
`default_nettype none
module hnc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire hnc_pkg::cmd_t cmd_i,
  output hnc_pkg::rsp_t      rsp_o,
  output logic               empty,
  input  wire logic          pop,
  output hnc_pkg::bstat_t    stat_o
);

  typedef enum logic [4:0] {
    B_INIT = 5'b00001,
    B_IDLE = 5'b00010,
    B_READ = 5'b00100,
    B_LOOK = 5'b01000,
    B_FILL = 5'b10000
  } bstate_e;

  localparam int TB = hnc_pkg::TableBits;

  bstate_e                        state_q, state_d;
  logic [hnc_pkg::RowBits-1:0]    row_q, row_d;
  logic [TB-1:0]                  addr_q, addr_d;
  logic [TB-1:0]                  probe_q, probe_d;
  logic [hnc_pkg::KeyW-1:0]       key_q, key_d;
  logic [63:0]                    fval_q, fval_d;
  logic                           fill_q, fill_d;
  logic                           clr_rep_q, clr_rep_d;
  logic [hnc_pkg::CountW-1:0]     count_q, count_d;
  hnc_pkg::rsp_t                  res_q, res_d;
  logic                           res_valid_q, res_valid_d;

  logic [hnc_pkg::KeyW-1:0]       name_mem [hnc_pkg::TblSize];
  logic [63:0]                    val_mem  [hnc_pkg::TblSize];
  logic [hnc_pkg::UsedW-1:0]      used_mem [hnc_pkg::UsedRows];
  logic [hnc_pkg::KeyW-1:0]       name_rd_q;
  logic [63:0]                    val_rd_q;
  logic [hnc_pkg::UsedW-1:0]      used_rd_q;

  logic                           name_we, val_we, used_we;
  logic [63:0]                    val_wd;
  logic [hnc_pkg::RowBits-1:0]    used_wa;
  logic [hnc_pkg::UsedW-1:0]      used_wd;
  logic                           used_bit;

  assign rsp_o       = res_q;
  assign empty       = !res_valid_q;
  assign cmd_ready_o = (state_q == B_IDLE) && !res_valid_q;
  assign used_bit    = used_rd_q[addr_q[hnc_pkg::UsedLo-1:0]];
  assign stat_o.init_busy  = (state_q == B_INIT);
  assign stat_o.used_count = count_q;

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    addr_d      = addr_q;
    probe_d     = probe_q;
    key_d       = key_q;
    fval_d      = fval_q;
    fill_d      = fill_q;
    clr_rep_d   = clr_rep_q;
    count_d     = count_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    name_we     = 1'b0;
    val_we      = 1'b0;
    val_wd      = fval_q;
    used_we     = 1'b0;
    used_wa     = addr_q[TB-1:hnc_pkg::UsedLo];
    used_wd     = used_rd_q;

    // Drop the result once taken
    if (pop && res_valid_q) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      B_INIT: begin
        // Sweep the in-use rows to zero
        used_we = 1'b1;
        used_wa = row_q;
        used_wd = '0;
        count_d = '0;
        if (row_q == hnc_pkg::RowBits'(hnc_pkg::UsedRows - 1)) begin
          state_d = B_IDLE;
          if (clr_rep_q) begin
            res_d       = '{status: hnc_pkg::ST_DONE, value: 64'd0, slot: '0};
            res_valid_d = 1'b1;
            clr_rep_d   = 1'b0;
          end
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      B_IDLE: begin
        if (cmd_valid_i && !res_valid_q) begin
          case (cmd_i.kind)
            hnc_pkg::CMD_LOOKUP: begin
              key_d   = cmd_i.key;
              addr_d  = cmd_i.home;
              probe_d = '0;
              fill_d  = 1'b0;
              state_d = B_READ;
            end
            hnc_pkg::CMD_FILL: begin
              addr_d  = cmd_i.fill_slot;
              fval_d  = cmd_i.value;
              fill_d  = 1'b1;
              state_d = B_READ;
            end
            hnc_pkg::CMD_CLEAR: begin
              row_d     = '0;
              clr_rep_d = 1'b1;
              state_d   = B_INIT;
            end
            hnc_pkg::CMD_BYPASS: begin
              res_d       = '{status: hnc_pkg::ST_BYPASS, value: 64'd0, slot: '0};
              res_valid_d = 1'b1;
            end
            default: begin
              res_d       = '{status: hnc_pkg::ST_INVALID, value: 64'd0, slot: '0};
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      B_READ: begin
        state_d = fill_q ? B_FILL : B_LOOK;
      end
      B_FILL: begin
        // Write the value only into a slot in use
        val_we      = used_bit;
        res_d       = '{status: hnc_pkg::ST_DONE, value: 64'd0, slot: '0};
        res_valid_d = 1'b1;
        state_d     = B_IDLE;
      end
      B_LOOK: begin
        if (!used_bit) begin
          if (count_q >= hnc_pkg::CountW'(hnc_pkg::TblSize - 1)) begin
            res_d = '{status: hnc_pkg::ST_BYPASS, value: 64'd0, slot: '0};
          end else begin
            // Claim the free slot
            name_we = 1'b1;
            val_we  = 1'b1;
            val_wd  = 64'd0;
            used_we = 1'b1;
            used_wd[addr_q[hnc_pkg::UsedLo-1:0]] = 1'b1;
            count_d = count_q + 1'b1;
            res_d   = '{status: hnc_pkg::ST_RESERVED, value: 64'd0,
                        slot: hnc_pkg::SlotW'(addr_q)};
          end
          res_valid_d = 1'b1;
          state_d     = B_IDLE;
        end else if (name_rd_q == key_q) begin
          res_d       = '{status: hnc_pkg::ST_HIT, value: val_rd_q,
                          slot: hnc_pkg::SlotW'(addr_q)};
          res_valid_d = 1'b1;
          state_d     = B_IDLE;
        end else if (&probe_q) begin
          res_d       = '{status: hnc_pkg::ST_BYPASS, value: 64'd0, slot: '0};
          res_valid_d = 1'b1;
          state_d     = B_IDLE;
        end else begin
          addr_d  = addr_q + 1'b1;
          probe_d = probe_q + 1'b1;
          state_d = B_READ;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Hold control state under reset; start with a sweep of the in-use rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_INIT;
      row_q       <= '0;
      clr_rep_q   <= 1'b0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      clr_rep_q   <= clr_rep_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    probe_q <= probe_d;
    key_q   <= key_d;
    fval_q  <= fval_d;
    fill_q  <= fill_d;
    res_q   <= res_d;
  end

  // Slot memories with registered reads
  always_ff @(posedge clk_i) begin
    if (name_we) begin
      name_mem[addr_q] <= key_q;
    end
    name_rd_q <= name_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[addr_q] <= val_wd;
    end
    val_rd_q <= val_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_rd_q <= used_mem[addr_q[TB-1:hnc_pkg::UsedLo]];
  end

endmodule
`default_nettype wire

FILE: sv/hashed_name_cache_unit.sv
// Top level of the hashed name cache unit.
`default_nettype none
`include "hashed_name_cache_unit_macros.svh"
// Name-to-value cache with FNV-1a hashing and linear probing over 1024 slots.
// A transaction takes a name lookup, a fill of a reserved slot, or a clear.
// The front end hashes one name byte per cycle, and the table engine then
// takes each probed slot through a registered memory read and a compare.
// A clear sweeps the 32 in-use bit rows; the same sweep runs after reset.
// Full is held high during any sweep. Outside a sweep, the front end can
// accept the next transaction while the engine works on earlier ones and
// a finished result waits to be popped.
module hashed_name_cache_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire hnc_pkg::req_t req_i,
  output logic               empty,
  input  wire logic          pop,
  output hnc_pkg::rsp_t      rsp_o
);

  hnc_pkg::cmd_t   fe_cmd, q_cmd;
  logic            fe_valid, fe_ready;
  logic            q_valid, q_ready;
  hnc_pkg::bstat_t bstat;

  hnc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .hold_i      (bstat.init_busy),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  hnc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_data_i  (fe_cmd),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_cmd)
  );

  hnc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .rsp_o       (rsp_o),
    .empty       (empty),
    .pop         (pop),
    .stat_o      (bstat)
  );

  // Check occupancy, reset and result shape
  `HNC_ASSERT(a_count_cap, bstat.used_count < hnc_pkg::CountW'(hnc_pkg::TblSize), "slot count overflow")
  `HNC_ASSERT(a_init_blocks, bstat.init_busy |-> full, "transaction accepted during sweep")
  `HNC_ASSERT(a_zero_fields, (!empty && (rsp_o.status != hnc_pkg::ST_HIT) && (rsp_o.status != hnc_pkg::ST_RESERVED)) |-> ((rsp_o.value == 64'd0) && (rsp_o.slot == 10'd0)), "nonzero fields in plain result")
  `HNC_ASSERT_RST(a_reset_empty, !rst_ni |=> empty, "result pending in reset")

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the hashed name cache unit.
`default_nettype none
module tb;

  typedef struct {
    hnc_pkg::req_t req;
    bit            take_reserved;
  } pending_t;

  typedef struct {
    logic [503:0] bytes;
    int           len;
  } name_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  hnc_pkg::req_t req_i = '0;
  logic full, empty;
  hnc_pkg::rsp_t rsp_o;

  hashed_name_cache_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req_i),
    .empty (empty),
    .pop   (pop),
    .rsp_o (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the table contents
  logic [503:0] shadow_names [hnc_pkg::TblSize];
  logic [63:0]  shadow_values[hnc_pkg::TblSize];
  bit           shadow_used  [hnc_pkg::TblSize];
  int           shadow_count;

  pending_t       pending_q[$];
  hnc_pkg::rsp_t  expected_rsp_q[$];
  logic [9:0]     reserved_slots[$];
  name_t          name_pool[$];
  int             fail_count = 0;

  // Compute the response of one transaction and update the shadow table
  function automatic hnc_pkg::rsp_t predict_cache_rsp(hnc_pkg::req_t r);
    hnc_pkg::rsp_t rsp;
    logic [511:0]  raw;
    logic [503:0]  key;
    logic [31:0]   h;
    logic [7:0]    b;
    logic [9:0]    s, home;
    int            scan, len;
    rsp = '0;
    raw = {r.name_word7, r.name_word6, r.name_word5, r.name_word4,
           r.name_word3, r.name_word2, r.name_word1, r.name_word0};
    case (hnc_pkg::action_e'(r.action))
      hnc_pkg::ACT_CLEAR: begin
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
        shadow_count = 0;
        reserved_slots.delete();
        rsp.status = hnc_pkg::ST_DONE;
        return rsp;
      end
      hnc_pkg::ACT_FILL: begin
        s = r.fill_slot;
        if (shadow_used[s]) shadow_values[s] = r.fill_value;
        rsp.status = hnc_pkg::ST_DONE;
        return rsp;
      end
      hnc_pkg::ACT_NONE: begin
        rsp.status = hnc_pkg::ST_INVALID;
        return rsp;
      end
      default: ;
    endcase
    // Find the end of the name
    len  = r.name_length;
    scan = (len < 63) ? len : 63;
    for (int i = 0; i < scan; i++) begin
      if (raw[8*i +: 8] == 8'h00) begin
        len = i;
        break;
      end
    end
    if (len == 0) begin
      rsp.status = hnc_pkg::ST_INVALID;
      return rsp;
    end
    if (len > hnc_pkg::NameMax) begin
      rsp.status = hnc_pkg::ST_BYPASS;
      return rsp;
    end
    key = '0;
    h   = hnc_pkg::FnvBasis;
    for (int i = 0; i < len; i++) begin
      b = raw[8*i +: 8];
      key[8*i +: 8] = b;
      h = (h ^ {24'd0, b}) * hnc_pkg::FnvPrime;
    end
    home = h[9:0];
    // Probe linearly from the home slot
    for (int p = 0; p < hnc_pkg::TblSize; p++) begin
      s = home + p[9:0];
      if (!shadow_used[s]) begin
        if (shadow_count + 1 >= hnc_pkg::TblSize) begin
          rsp.status = hnc_pkg::ST_BYPASS;
          return rsp;
        end
        shadow_names[s]  = key;
        shadow_values[s] = '0;
        shadow_used[s]   = 1'b1;
        shadow_count++;
        reserved_slots.push_back(s);
        rsp.status = hnc_pkg::ST_RESERVED;
        rsp.slot   = s;
        return rsp;
      end
      if (shadow_names[s] == key) begin
        rsp.status = hnc_pkg::ST_HIT;
        rsp.value  = shadow_values[s];
        rsp.slot   = s;
        return rsp;
      end
    end
    rsp.status = hnc_pkg::ST_BYPASS;
    return rsp;
  endfunction

  // Build a lookup: random bytes past len, zero at len if req_len > len
  function automatic hnc_pkg::req_t lookup_req(logic [503:0] bytes, int len, int req_len);
    hnc_pkg::req_t r;
    logic [511:0]  raw;
    r = '0;
    for (int i = 0; i < 64; i++) raw[8*i +: 8] = (i < len && i < 63) ? bytes[8*i +: 8]
                                                                     : 8'($urandom);
    if (len < 64) raw[8*len +: 8] = (req_len > len) ? 8'h00 : raw[8*len +: 8];
    {r.name_word7, r.name_word6, r.name_word5, r.name_word4,
     r.name_word3, r.name_word2, r.name_word1, r.name_word0} = raw;
    r.action      = hnc_pkg::ACT_LOOKUP;
    r.name_length = 7'(req_len);
    r.fill_slot   = 10'($urandom);
    r.fill_value  = {$urandom, $urandom};
    return r;
  endfunction

  function automatic name_t random_name(int len);
    name_t n;
    n.bytes = '0;
    n.len   = len;
    for (int i = 0; i < len; i++) n.bytes[8*i +: 8] = 8'($urandom_range(1, 255));
    return n;
  endfunction

  task automatic add_lookup(name_t n);
    pending_t p;
    p.req = lookup_req(n.bytes, n.len, n.len);
    p.take_reserved = 1'b0;
    pending_q.push_back(p);
  endtask

  task automatic add_raw(hnc_pkg::action_e act, logic [9:0] slot, logic [63:0] value,
                         bit from_reserved);
    pending_t p;
    p.req = lookup_req('0, 0, $urandom_range(0, 127));
    p.req.action     = act;
    p.req.fill_slot  = slot;
    p.req.fill_value = value;
    p.take_reserved  = from_reserved;
    pending_q.push_back(p);
  endtask

  // Feed transactions in bursts with random gaps
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk_i) begin
    pending_t p;
    int       k;
    if (rst_ni) begin
      if (push && !full) expected_rsp_q.push_back(predict_cache_rsp(req_i));
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_q.size() > 0) begin
          p = pending_q.pop_front();
          if (p.take_reserved && reserved_slots.size() > 0) begin
            k = $urandom_range(0, reserved_slots.size() - 1);
            p.req.fill_slot = reserved_slots[k];
            reserved_slots.delete(k);
          end
          req_i <= p.req;
          push  <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left--;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Check each popped response against the oldest expectation
  int pop_cycle = 0;
  always @(posedge clk_i) begin
    hnc_pkg::rsp_t want;
    int            mode;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected response status %0d", rsp_o.status);
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_o.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp_o.status);
            fail_count++;
          end
          if (rsp_o.value !== want.value) begin
            $error("value expected %h actual %h", want.value, rsp_o.value);
            fail_count++;
          end
          if (rsp_o.slot !== want.slot) begin
            $error("slot expected %0d actual %0d", want.slot, rsp_o.slot);
            fail_count++;
          end
        end
      end
      pop_cycle++;
      mode = (pop_cycle / 300) % 3;
      pop <= (mode == 0) ? 1'b1 : (mode == 1) ? 1'($urandom) : ($urandom_range(0, 7) == 0);
    end
  end

  initial begin
    #(12 * 20000000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    name_t n;
    int    r;
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    shadow_count = 0;
    for (int i = 0; i < 60; i++)
      name_pool.push_back(random_name(($urandom_range(0, 4) == 0) ? $urandom_range(13, 63)
                                                                   : $urandom_range(1, 12)));

    // Directed: empty, embedded zero, extremes, every action
    begin
      pending_t p;
      p.take_reserved = 1'b0;
      p.req = lookup_req('0, 0, 0);
      pending_q.push_back(p);
      p.req = lookup_req('0, 0, 5);
      pending_q.push_back(p);
      n = random_name(3);
      p.req = lookup_req(n.bytes, 3, 9);
      pending_q.push_back(p);
      add_lookup(n);
      p.req = lookup_req('1, 63, 63);
      pending_q.push_back(p);
      add_lookup(name_t'{'1, 63});
      p.req = lookup_req('1, 64, 64);
      pending_q.push_back(p);
      p.req = lookup_req('1, 64, 127);
      pending_q.push_back(p);
      n = random_name(20);
      p.req = lookup_req(n.bytes, 20, 127);
      pending_q.push_back(p);
    end
    add_raw(hnc_pkg::ACT_NONE, '1, '1, 1'b0);
    add_raw(hnc_pkg::ACT_FILL, 10'd1023, '1, 1'b0);
    add_raw(hnc_pkg::ACT_FILL, 10'd0, '0, 1'b0);
    add_lookup(name_pool[0]);
    add_raw(hnc_pkg::ACT_FILL, 0, '0, 1'b1);
    add_lookup(name_pool[0]);
    add_lookup(name_pool[1]);
    add_raw(hnc_pkg::ACT_FILL, 0, '1, 1'b1);
    add_lookup(name_pool[1]);
    add_raw(hnc_pkg::ACT_CLEAR, 0, 0, 1'b0);
    add_lookup(name_pool[1]);

    // Random mix of lookups, fills, clears and invalid actions
    for (int i = 0; i < 60; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) add_lookup(name_pool[$urandom_range(0, name_pool.size() - 1)]);
      else if (r < 50) add_lookup(random_name($urandom_range(1, 63)));
      else if (r < 55) begin
        pending_t p;
        p.take_reserved = 1'b0;
        n = name_pool[$urandom_range(0, name_pool.size() - 1)];
        p.req = lookup_req(n.bytes, n.len, $urandom_range(0, 127));
        pending_q.push_back(p);
      end else if (r < 85) add_raw(hnc_pkg::ACT_FILL, 0, {$urandom, $urandom}, 1'b1);
      else if (r < 92) add_raw(hnc_pkg::ACT_FILL, 10'($urandom), {$urandom, $urandom}, 1'b0);
      else if (r < 95) add_raw(hnc_pkg::ACT_NONE, 10'($urandom), {$urandom, $urandom}, 1'b0);
      else if (r < 97) add_raw(hnc_pkg::ACT_CLEAR, 10'($urandom), {$urandom, $urandom}, 1'b0);
      else add_raw(hnc_pkg::ACT_FILL, 0, '0, 1'b1);
    end

    // Drive the table to its nearly full limit with distinct short names
    add_raw(hnc_pkg::ACT_CLEAR, 0, 0, 1'b0);
    for (int k = 0; k < 1030; k++) begin
      n.bytes = '0;
      n.bytes[7:0]  = 8'(k % 255 + 1);
      n.bytes[15:8] = 8'(k / 255 + 1);
      n.len = 2;
      add_lookup(n);
    end
    for (int i = 0; i < 20; i++) begin
      add_lookup(name_pool[i]);
      add_raw(hnc_pkg::ACT_FILL, 0, {$urandom, $urandom}, 1'b1);
    end
    add_raw(hnc_pkg::ACT_CLEAR, 0, 0, 1'b0);
    add_lookup(name_pool[2]);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all stimulus accepted, then all responses seen
    while (pending_q.size() > 0 || push) @(posedge clk_i);
    while (expected_rsp_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/hnc_pkg.sv
sv/hnc_front.sv
sv/hnc_queue.sv
sv/hnc_back.sv
sv/hashed_name_cache_unit.sv
sim/tb.sv
